// ===== rtl/core/multi_reader_overwrite_ring_assert.svh =====
// Assertion macros used by the port-level checker.
`ifndef MULTI_READER_OVERWRITE_RING_ASSERT_SVH
`define MULTI_READER_OVERWRITE_RING_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MROR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MROR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/mror_pkg.sv =====
// Package: types, codes and defaults of the overwrite ring.
package mror_pkg;
    localparam int RING_DEPTH_DEF   = 16;
    localparam int READER_SLOTS_DEF = 8;
    localparam int WORD_BITS_DEF    = 64;
    localparam int NOTIFY_SLOTS     = 8;
    localparam int RESULT_LIMIT     = 16;
    localparam int FIFO_DEPTH       = 2;

    localparam logic [1:0] OP_PUBLISH   = 2'd0;
    localparam logic [1:0] OP_SUBSCRIBE = 2'd1;
    localparam logic [1:0] OP_FETCH     = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_ITEM     = 2'd1;
    localparam logic [1:0] CFG_ISR      = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_SIZE     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STREAM
    } t_back_state;
endpackage

// ===== rtl/core/mror_front.sv =====
// Front end: accept input items, drop unused op codes, queue the rest.
module mror_front
    import mror_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_reader_id,
    input  logic                 i_want_notify,
    input  logic [WORD_BITS-1:0] i_payload,
    input  logic [3:0]           i_payload_bytes,
    input  logic [4:0]           i_fetch_count,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output logic [1:0]           o_op,
    output logic [7:0]           o_reader_id,
    output logic                 o_want_notify,
    output logic [WORD_BITS-1:0] o_payload,
    output logic [3:0]           o_payload_bytes,
    output logic [4:0]           o_fetch_count
);
    localparam int EW = 2 + 8 + 1 + WORD_BITS + 4 + 5;
    logic [EW-1:0] r_mem [FIFO_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;

    assign o_ready   = (r_cnt != 2'(FIFO_DEPTH));
    assign pop       = i_q_pop && (r_cnt != 2'd0);
    assign push      = i_valid && o_ready && (i_op != OP_UNUSED);
    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_op, o_reader_id, o_want_notify, o_payload, o_payload_bytes, o_fetch_count}
        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= {i_op, i_reader_id, i_want_notify, i_payload,
                            i_payload_bytes, i_fetch_count};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/core/mror_back.sv =====
// Back end: ring store, reader table and fetch streaming.
module mror_back
    import mror_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int READER_SLOTS = READER_SLOTS_DEF,
    parameter int WORD_BITS    = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [4:0]           i_cfg_data,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_reader_id,
    input  logic                 i_want_notify,
    input  logic [WORD_BITS-1:0] i_payload,
    input  logic [3:0]           i_payload_bytes,
    input  logic [4:0]           i_fetch_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_status,
    output logic [WORD_BITS-1:0] o_item_word,
    output logic [4:0]           o_delivered,
    output logic                 o_last,
    output logic [7:0]           o_notify_mask
);
    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
    localparam int CHECK = (READER_SLOTS < NOTIFY_SLOTS) ? READER_SLOTS : NOTIFY_SLOTS;

    logic [WORD_BITS-1:0] r_ring [RING_DEPTH];
    logic [4:0]           r_capacity;
    logic [3:0]           r_item_bytes;
    logic                 r_isr;
    logic [PW-1:0]        r_wpos;
    logic [31:0]          r_wtotal;
    logic [READER_SLOTS-1:0] r_used;
    logic [7:0]           r_reader [READER_SLOTS];
    logic                 r_notify [READER_SLOTS];
    logic [PW-1:0]        r_spos [READER_SLOTS];
    logic [31:0]          r_rtotal [READER_SLOTS];

    t_back_state          r_state, n_state;
    logic [PW-1:0]        r_fpos;
    logic [4:0]           r_left, r_n;
    logic [SW-1:0]        r_fslot;

    logic                 r_ov;
    logic [2:0]           r_st;
    logic [WORD_BITS-1:0] r_word;
    logic [4:0]           r_dlv;
    logic                 r_lst;
    logic [7:0]           r_msk;

    logic [CW-1:0]        cap;
    logic                 out_free;
    logic                 hit, has_free;
    logic [SW-1:0]        hit_slot, free_slot;
    logic [31:0]          unread;
    logic [7:0]           mask;
    logic [WORD_BITS-1:0] word_mask;
    logic [6:0]           bits;
    logic [PW-1:0]        wpos_inc, fpos_inc;

    always_comb begin
        if (r_capacity == 5'd0) cap = CW'(1);
        else if (32'(r_capacity) > RING_DEPTH) cap = CW'(RING_DEPTH);
        else cap = CW'(r_capacity);
    end

    assign out_free = !r_ov || i_ready;

    always_comb begin
        hit = 1'b0; hit_slot = '0; has_free = 1'b0; free_slot = '0;
        for (int s = READER_SLOTS - 1; s >= 0; s--) begin
            if (r_used[s] && r_reader[s] == i_reader_id) begin
                hit = 1'b1; hit_slot = SW'(s);
            end
            if (!r_used[s]) begin
                has_free = 1'b1; free_slot = SW'(s);
            end
        end
        mask = '0;
        for (int s = 0; s < CHECK; s++) begin
            mask[s] = r_used[s] && r_notify[s] && (r_reader[s] != 8'd0);
        end
    end

    assign unread = r_wtotal - r_rtotal[hit_slot];
    assign bits = ({3'd0, r_item_bytes} << 3) > 7'(WORD_BITS)
                  ? 7'(WORD_BITS) : ({3'd0, r_item_bytes} << 3);
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) word_mask[b] = (7'(b) < bits);
    end
    assign wpos_inc = ((CW'(r_wpos) + CW'(1)) >= cap) ? '0 : r_wpos + PW'(1);
    assign fpos_inc = ((CW'(r_fpos) + CW'(1)) >= cap) ? '0 : r_fpos + PW'(1);

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (o_q_pop && i_op == OP_FETCH && hit && i_fetch_count != 5'd0
                          && unread != 32'd0 && !unread[31]) n_state = S_STREAM;
            S_STREAM: if (out_free && r_left == 5'd1) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic [31:0] u;
        logic [4:0]  nn;
        u  = unread;
        nn = '0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_capacity <= 5'd16; r_item_bytes <= 4'd4; r_isr <= 1'b0;
            r_wpos <= '0; r_wtotal <= '0; r_used <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_capacity <= i_cfg_data;
                    CFG_ITEM:     r_item_bytes <= i_cfg_data[3:0];
                    CFG_ISR:      r_isr <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (out_free) r_ov <= 1'b0;
            if (o_q_pop) begin
                r_ov <= 1'b1; r_st <= ST_OK; r_word <= '0; r_dlv <= '0;
                r_lst <= 1'b1; r_msk <= '0;
                case (i_op)
                    OP_PUBLISH: begin
                        if (i_payload_bytes != r_item_bytes) r_st <= ST_SIZE;
                        else begin
                            r_ring[r_wpos] <= i_payload & word_mask;
                            r_wpos <= wpos_inc;
                            r_wtotal <= r_wtotal + 32'd1;
                            if (!r_isr) r_msk <= mask;
                        end
                    end
                    OP_SUBSCRIBE: begin
                        if (!hit) begin
                            if (has_free) begin
                                r_used[free_slot] <= 1'b1;
                                r_reader[free_slot] <= i_reader_id;
                                r_notify[free_slot] <= i_want_notify;
                                r_spos[free_slot] <= '0;
                                r_rtotal[free_slot] <= '0;
                            end else r_st <= ST_FULL;
                        end
                    end
                    default: begin
                        if (!hit) r_st <= ST_UNKNOWN;
                        else if (i_fetch_count == 5'd0) r_st <= ST_OK;
                        else if (u == 32'd0 || u[31]) r_st <= ST_EMPTY;
                        else begin
                            r_ov <= 1'b0;
                            r_fslot <= hit_slot;
                            r_fpos <= r_spos[hit_slot];
                            if (u >= 32'(cap)) begin
                                u = 32'(cap);
                                r_fpos <= r_wpos;
                            end
                            nn = (32'(i_fetch_count) < u) ? i_fetch_count : u[4:0];
                            if (nn > 5'(RESULT_LIMIT)) nn = 5'(RESULT_LIMIT);
                            r_n <= nn; r_left <= nn;
                            r_rtotal[hit_slot] <= r_wtotal - u + 32'(nn);
                        end
                    end
                endcase
            end
            if (r_state == S_STREAM && out_free) begin
                r_ov <= 1'b1; r_st <= ST_OK; r_word <= r_ring[r_fpos];
                r_dlv <= r_n; r_lst <= (r_left == 5'd1); r_msk <= '0;
                r_fpos <= fpos_inc;
                r_left <= r_left - 5'd1;
                if (r_left == 5'd1) r_spos[r_fslot] <= fpos_inc;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_item_word = r_word;
    assign o_delivered = r_dlv;
    assign o_last = r_lst;
    assign o_notify_mask = r_msk;
endmodule

// ===== rtl/core/multi_reader_overwrite_ring.sv =====
// Top level of the multi-reader overwrite ring.
// Channel  | direction | handshake             | contents
// s_axis   | in        | tvalid/tready         | op, reader_id, payload, ...
// m_axis   | out       | tvalid/tready         | status, item_word, delivered, ...
// cfg      | in        | i_cfg_valid/o_cfg_ready | register index, data
// Publish and subscribe give one result each; a fetch of n words is popped and then
// reads n ring words, one per cycle while not stalled, from the register-file ring.
// A two-entry queue parts the front from the back; the output register
// holds a result while m_axis_tready is low and stalls the back end.
// Reset is synchronous, active low; the ring store is not cleared.
module multi_reader_overwrite_ring
    import mror_pkg::*;
#(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int READER_SLOTS = READER_SLOTS_DEF,
    parameter int WORD_BITS    = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], reader_id[9:2], want_notify[10], payload, payload_bytes, fetch_count
    input  logic [((WORD_BITS+20+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], item_word, delivered, notify_mask
    output logic [((WORD_BITS+16+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);
    localparam int IW = ((WORD_BITS + 20 + 7) / 8) * 8;
    localparam int OW = ((WORD_BITS + 16 + 7) / 8) * 8;
    logic                 q_valid, q_pop, f_want;
    logic [1:0]           f_op;
    logic [7:0]           f_id;
    logic [WORD_BITS-1:0] f_pay;
    logic [3:0]           f_pb;
    logic [4:0]           f_fc;
    logic [2:0]           st;
    logic [WORD_BITS-1:0] word;
    logic [4:0]           dlv;
    logic [7:0]           msk;

    assign o_cfg_ready = 1'b1;

    mror_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[1:0]), .i_reader_id(s_axis_tdata[9:2]),
        .i_want_notify(s_axis_tdata[10]),
        .i_payload(s_axis_tdata[11 +: WORD_BITS]),
        .i_payload_bytes(s_axis_tdata[11+WORD_BITS +: 4]),
        .i_fetch_count(s_axis_tdata[15+WORD_BITS +: 5]),
        .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_op(f_op), .o_reader_id(f_id), .o_want_notify(f_want),
        .o_payload(f_pay), .o_payload_bytes(f_pb), .o_fetch_count(f_fc)
    );

    mror_back #(.RING_DEPTH(RING_DEPTH), .READER_SLOTS(READER_SLOTS),
                .WORD_BITS(WORD_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_op(f_op), .i_reader_id(f_id), .i_want_notify(f_want),
        .i_payload(f_pay), .i_payload_bytes(f_pb), .i_fetch_count(f_fc),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(st), .o_item_word(word), .o_delivered(dlv),
        .o_last(m_axis_tlast), .o_notify_mask(msk)
    );

    assign m_axis_tdata = OW'({msk, dlv, word, st});
    logic unused_in;
    assign unused_in = |s_axis_tdata[IW-1:20+WORD_BITS] | 1'b0;
endmodule

// ===== rtl/core/mror_checker.sv =====
// Port-level checker for the overwrite ring, bound to the top level.
`include "multi_reader_overwrite_ring_assert.svh"
module mror_checker
    import mror_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic        m_axis_tlast,
    input logic [79:0] m_axis_tdata
);
    logic [2:0]  st;
    logic [68:0] word_dlv;
    logic [4:0]  dlv;
    logic [7:0]  msk;
    logic        stall;

    assign st       = m_axis_tdata[2:0];
    assign word_dlv = m_axis_tdata[71:3];
    assign dlv      = m_axis_tdata[71:67];
    assign msk      = m_axis_tdata[79:72];
    assign stall    = m_axis_tvalid && !m_axis_tready;

    `MROR_ASSERT_NXT(a_hold, i_clk, i_rst_n, stall, m_axis_tvalid && $stable(m_axis_tdata))
    `MROR_ASSERT_IMP(a_status, i_clk, i_rst_n, m_axis_tvalid, st <= ST_FULL)
    `MROR_ASSERT_IMP(a_word, i_clk, i_rst_n, m_axis_tvalid && st != ST_OK, !(|word_dlv) && m_axis_tlast)
    `MROR_ASSERT_IMP(a_dlv, i_clk, i_rst_n, m_axis_tvalid && dlv != 5'd0, msk == 8'd0)
endmodule

bind multi_reader_overwrite_ring mror_checker u_mror_checker (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tlast,
    .m_axis_tdata(m_axis_tdata[79:0])
);

// ===== verif/multi_reader_overwrite_ring_chk.sv =====
`timescale 1ns / 100ps
// Checker for the overwrite ring: tracks config, predicts results, compares output transactions.
module multi_reader_overwrite_ring_chk
    import mror_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [87:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [79:0] i_out_data,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_result_count
);
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] word;
        logic [4:0]  delivered;
        logic        last;
        logic [7:0]  mask;
    } t_result;

    t_result     expected_results[$];
    logic [63:0] ring_words [16];
    logic [3:0]  wr_pos;
    logic [31:0] wr_total;
    logic        slot_used [8];
    logic [7:0]  slot_id [8];
    logic        slot_notify [8];
    logic [3:0]  slot_rd_pos [8];
    logic [31:0] slot_rd_total [8];
    logic [4:0]  cap_reg;
    logic [3:0]  item_bytes_reg;
    logic        isr_reg;

    function automatic int eff_capacity();
        if (cap_reg == 0) return 1;
        if (cap_reg > 16) return 16;
        return int'(cap_reg);
    endfunction

    function automatic void push_result(logic [2:0] st, logic [63:0] w, logic [4:0] n,
                                        logic lst, logic [7:0] m);
        t_result r;
        r.status = st; r.word = w; r.delivered = n; r.last = lst; r.mask = m;
        expected_results.push_back(r);
    endfunction

    function automatic int find_reader(logic [7:0] id);
        for (int s = 0; s < 8; s++)
            if (slot_used[s] && slot_id[s] == id) return s;
        return -1;
    endfunction

    // Apply one input transaction to the shadow state and queue its results.
    function automatic void predict_ring_op(logic [87:0] d);
        logic [1:0]  op;
        logic [7:0]  id;
        logic [63:0] payload;
        logic [3:0]  pbytes;
        logic [4:0]  want;
        logic [7:0]  m;
        logic [31:0] unread;
        int          cap, s, n, p, bits;
        op = d[1:0]; id = d[9:2]; payload = d[74:11]; pbytes = d[78:75]; want = d[83:79];
        cap = eff_capacity();
        m = '0;
        case (op)
            OP_PUBLISH: begin
                if (pbytes != item_bytes_reg) begin
                    push_result(ST_SIZE, '0, '0, 1'b1, '0);
                end else begin
                    bits = int'(item_bytes_reg) * 8;
                    ring_words[wr_pos] = (bits >= 64) ? payload
                                         : payload & ((64'd1 << bits) - 64'd1);
                    wr_pos = (int'(wr_pos) + 1 >= cap) ? 4'd0 : wr_pos + 4'd1;
                    wr_total = wr_total + 32'd1;
                    if (!isr_reg)
                        for (int k = 0; k < 8; k++)
                            if (slot_used[k] && slot_notify[k] && slot_id[k] != 0) m[k] = 1'b1;
                    push_result(ST_OK, '0, '0, 1'b1, m);
                end
            end
            OP_SUBSCRIBE: begin
                s = find_reader(id);
                if (s < 0)
                    for (int k = 0; k < 8; k++)
                        if (!slot_used[k] && s < 0) s = k + 100;
                if (s >= 100) begin
                    s -= 100;
                    slot_used[s] = 1'b1; slot_id[s] = id; slot_notify[s] = d[10];
                    slot_rd_pos[s] = '0; slot_rd_total[s] = '0;
                    push_result(ST_OK, '0, '0, 1'b1, '0);
                end else if (s >= 0) begin
                    push_result(ST_OK, '0, '0, 1'b1, '0);
                end else begin
                    push_result(ST_FULL, '0, '0, 1'b1, '0);
                end
            end
            OP_FETCH: begin
                s = find_reader(id);
                if (s < 0) begin
                    push_result(ST_UNKNOWN, '0, '0, 1'b1, '0);
                end else if (want == 0) begin
                    push_result(ST_OK, '0, '0, 1'b1, '0);
                end else begin
                    unread = wr_total - slot_rd_total[s];
                    if (unread == 0 || unread[31]) begin
                        push_result(ST_EMPTY, '0, '0, 1'b1, '0);
                    end else begin
                        // Reader lapped: jump to the oldest entry still held.
                        if (unread >= 32'(cap)) begin
                            slot_rd_total[s] = wr_total - 32'(cap);
                            slot_rd_pos[s] = wr_pos;
                            unread = 32'(cap);
                        end
                        n = (32'(want) < unread) ? int'(want) : int'(unread);
                        if (n > RESULT_LIMIT) n = RESULT_LIMIT;
                        slot_rd_total[s] = slot_rd_total[s] + 32'(n);
                        p = int'(slot_rd_pos[s]);
                        for (int i = 0; i < n; i++) begin
                            push_result(ST_OK, ring_words[p], 5'(n), i + 1 == n, '0);
                            p = (p + 1 >= cap) ? 0 : p + 1;
                        end
                        slot_rd_pos[s] = 4'(p);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            expected_results.delete();
            wr_pos = '0;
            wr_total = '0;
            for (int k = 0; k < 8; k++) slot_used[k] = 1'b0;
            cap_reg = 5'd16;
            item_bytes_reg = 4'd4;
            isr_reg = 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CAPACITY: cap_reg = i_cfg_data;
                    CFG_ITEM:     item_bytes_reg = i_cfg_data[3:0];
                    CFG_ISR:      isr_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                got.status = i_out_data[2:0];
                got.word = i_out_data[66:3];
                got.delivered = i_out_data[71:67];
                got.last = i_out_last;
                got.mask = i_out_data[79:72];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected st=%0d word=%h dlv=%0d last=%0d mask=%h",
                                 $time, exp_r.status, exp_r.word, exp_r.delivered, exp_r.last,
                                 exp_r.mask);
                        $display("%0t:          actual   st=%0d word=%h dlv=%0d last=%0d mask=%h",
                                 $time, got.status, got.word, got.delivered, got.last, got.mask);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_ring_op(i_in_data);
        end
        o_pending <= expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        o_pending = 0;
    end
endmodule

// ===== verif/multi_reader_overwrite_ring_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the overwrite ring: stimulus, flow control, watchdog and verdict.
module multi_reader_overwrite_ring_tb;
    import mror_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_CAPACITY;
    logic [4:0]  i_cfg_data = '0;
    int          pending, fail_count, result_count;
    bit          bursts_on = 1'b1;
    bit          hold_req = 1'b0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    logic [7:0]  reader_pool [10] = '{8'd3, 8'd17, 8'd0, 8'd255, 8'd200,
                                      8'd42, 8'd9, 8'd128, 8'd77, 8'd5};
    logic [3:0]  cur_item_bytes = 4'd4;

    always #6 i_clk = ~i_clk;

    multi_reader_overwrite_ring dut (.*);

    multi_reader_overwrite_ring_chk chk (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .i_out_data(m_axis_tdata),
        .i_out_last(m_axis_tlast),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_fail_count(fail_count), .o_result_count(result_count)
    );

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (150) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (bursts_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 4000) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [87:0] pack_item(logic [1:0] op, logic [7:0] id, logic notify,
                                              logic [63:0] payload, logic [3:0] pbytes,
                                              logic [4:0] cnt);
        return {4'b0, cnt, pbytes, payload, notify, id, op};
    endfunction

    task automatic send_item(logic [87:0] d);
        bit taken;
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tdata <= d;
        s_axis_tvalid <= 1'b1;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic publish(logic [63:0] w, logic [3:0] b);
        send_item(pack_item(OP_PUBLISH, 8'($urandom), 1'($urandom), w, b, 5'($urandom)));
    endtask

    task automatic subscribe(logic [7:0] id, logic notify);
        send_item(pack_item(OP_SUBSCRIBE, id, notify, {$urandom, $urandom}, 4'($urandom),
                            5'($urandom)));
    endtask

    task automatic fetch(logic [7:0] id, logic [4:0] cnt);
        send_item(pack_item(OP_FETCH, id, 1'($urandom), {$urandom, $urandom}, 4'($urandom),
                            cnt));
    endtask

    task automatic send_random();
        int pick;
        logic [3:0] b;
        logic [7:0] id;
        pick = $urandom_range(0, 99);
        id = ($urandom_range(0, 6) == 0) ? 8'($urandom) : reader_pool[$urandom_range(0, 9)];
        if (pick < 45) begin
            b = ($urandom_range(0, 9) == 0) ? 4'($urandom) : cur_item_bytes;
            publish({$urandom, $urandom}, b);
        end else if (pick < 58) begin
            subscribe(id, 1'($urandom));
        end else if (pick < 96) begin
            fetch(id, ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16)));
        end else begin
            // Unused opcode: no result expected.
            send_item(pack_item(OP_UNUSED, id, 1'b0, {$urandom, $urandom}, 4'($urandom),
                                5'($urandom)));
        end
    endtask

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        bit taken;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        logic [4:0] caps  [6] = '{5'd1, 5'd16, 5'd5, 5'd0, 5'd31, 5'd7};
        logic [4:0] sizes [6] = '{5'd1, 5'd8, 5'd3, 5'd15, 5'd2, 5'd8};
        logic       isrs  [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: registration, corner statuses, a full ring write, lapping, full table.
        subscribe(8'd0, 1'b1);
        subscribe(8'd255, 1'b1);
        subscribe(8'd3, 1'b0);
        subscribe(8'd3, 1'b1);
        fetch(8'd99, 5'd4);
        fetch(8'd3, 5'd0);
        fetch(8'd3, 5'd5);
        publish('1, 4'd8);
        publish('1, 4'd4);
        publish('0, 4'd4);
        fetch(8'd255, 5'd31);
        for (int i = 0; i < 16; i++) publish({$urandom, $urandom}, 4'd4);
        fetch(8'd3, 5'd31);
        subscribe(8'd17, 1'b1);
        subscribe(8'd200, 1'b0);
        subscribe(8'd42, 1'b1);
        subscribe(8'd9, 1'b1);
        subscribe(8'd128, 1'b1);
        subscribe(8'd77, 1'b1);
        send_item(pack_item(OP_UNUSED, 8'd1, 1'b1, '1, 4'hf, 5'h1f));

        for (int i = 0; i < 40; i++) begin
            if (i == 10) hold_req = 1'b1;
            send_random();
        end
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(CFG_CAPACITY, caps[ph]);
            write_reg(CFG_ITEM, sizes[ph]);
            write_reg(CFG_ISR, 5'(isrs[ph]));
            i_cfg_valid <= 1'b0;
            cur_item_bytes = sizes[ph][3:0];
            if (ph == 5) bursts_on = 1'b0;
            for (int i = 0; i < 45; i++) send_random();
        end
        drain();

        $display("Sent %0d items over 7 register settings; %0d results checked.",
                 items_sent, result_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
